### design/rpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpfa_pkg;

    localparam int NUM_FRAMES = 1024;
    localparam int FRAME_BITS = $clog2(NUM_FRAMES);
    localparam int COUNT_BITS = 8;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_PEEK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_UNDER = 2'd2,
        STAT_OVER  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_EXEC,
        ST_LINK_A,
        ST_LINK_B
    } state_t;

endpackage
`default_nettype wire

### design/refcounted_page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Page frame allocator with a circular doubly linked free list and a
// reference count per frame. After reset the block sweeps its link, list and
// count memories once, one frame per cycle, so busy stays high until the
// sweep ends. A command word is taken when start is high and busy is low;
// busy then stays high until the result word is shown, but an allocate on
// an empty list leaves it low. The result is on frame_out, status,
// ref_count and list_empty for exactly one cycle, marked by done, and the
// receiver cannot hold it off. Each step reads and writes synchronous
// memories with separate read and write addresses and registered read
// data: a reserve, a release that leaves the count above zero, a release
// into an empty list, an overflow or underflow on a reserve or release,
// and a peek pass through ST_EXEC alone; an allocate passes through
// ST_ALLOC and then ST_EXEC, since the frame to take is itself read from
// the link memory; a release that returns a frame to a non-empty list
// needs two more link write steps, ST_LINK_A and ST_LINK_B. Allocate on an
// empty list answers in the next cycle. Any error leaves the state untouched.
module refcounted_page_frame_allocator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] cmd,
    input  wire logic [9:0] frame,
    output logic            busy,
    output logic            done,
    output logic [9:0]      frame_out,
    output logic [1:0]      status,
    output logic [7:0]      ref_count,
    output logic            list_empty
);
    import rpfa_pkg::*;

    localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(NUM_FRAMES - 1);

    // State memories.
    logic [FRAME_BITS-1:0] nl_mem [NUM_FRAMES];
    logic [FRAME_BITS-1:0] pl_mem [NUM_FRAMES];
    logic                  ol_mem [NUM_FRAMES];
    logic [COUNT_BITS-1:0] rc_mem [NUM_FRAMES];

    logic [FRAME_BITS-1:0] nl_rd_reg, pl_rd_reg;
    logic                  ol_rd_reg;
    logic [COUNT_BITS-1:0] rc_rd_reg;

    logic [FRAME_BITS-1:0] nl_ra, pl_ra, ol_ra, rc_ra;
    logic                  nl_we, pl_we, ol_we, rc_we;
    logic [FRAME_BITS-1:0] nl_wa, pl_wa, ol_wa, rc_wa;
    logic [FRAME_BITS-1:0] nl_wd, pl_wd;
    logic                  ol_wd;
    logic [COUNT_BITS-1:0] rc_wd;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [FRAME_BITS-1:0] f_reg, f_next;
    logic [FRAME_BITS-1:0] head_reg, head_next;
    logic                  hv_reg, hv_next;
    logic [FRAME_BITS-1:0] idx_reg, idx_next;

    logic                  done_reg, done_next;
    logic [FRAME_BITS-1:0] fo_reg, fo_next;
    status_t               stat_reg, stat_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  empty_reg, empty_next;

    logic [COUNT_BITS-1:0] rc_inc, rc_dec;
    logic [FRAME_BITS-1:0] frame_idx;

    assign rc_inc    = rc_rd_reg + COUNT_BITS'(1);
    assign rc_dec    = rc_rd_reg - COUNT_BITS'(1);
    assign frame_idx = frame[FRAME_BITS-1:0];

    always_ff @(posedge clk) begin
        if (nl_we)
        begin
            nl_mem[nl_wa] <= nl_wd;
        end
        if (pl_we)
        begin
            pl_mem[pl_wa] <= pl_wd;
        end
        if (ol_we)
        begin
            ol_mem[ol_wa] <= ol_wd;
        end
        if (rc_we)
        begin
            rc_mem[rc_wa] <= rc_wd;
        end
        nl_rd_reg <= nl_mem[nl_ra];
        pl_rd_reg <= pl_mem[pl_ra];
        ol_rd_reg <= ol_mem[ol_ra];
        rc_rd_reg <= rc_mem[rc_ra];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            head_reg  <= '0;
            hv_reg    <= 1'b1;
            done_reg  <= 1'b0;
            cmd_reg   <= CMD_ALLOC;
            f_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            head_reg  <= head_next;
            hv_reg    <= hv_next;
            done_reg  <= done_next;
            cmd_reg   <= cmd_next;
            f_reg     <= f_next;
        end
    end

    always_ff @(posedge clk) begin
        fo_reg    <= fo_next;
        stat_reg  <= stat_next;
        cnt_reg   <= cnt_next;
        empty_reg <= empty_next;
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        f_next     = f_reg;
        head_next  = head_reg;
        hv_next    = hv_reg;
        done_next  = 1'b0;
        fo_next    = fo_reg;
        stat_next  = stat_reg;
        cnt_next   = cnt_reg;
        empty_next = empty_reg;
        nl_ra = f_reg;
        pl_ra = f_reg;
        ol_ra = f_reg;
        rc_ra = f_reg;
        nl_we = 1'b0; nl_wa = f_reg; nl_wd = f_reg;
        pl_we = 1'b0; pl_wa = f_reg; pl_wd = f_reg;
        ol_we = 1'b0; ol_wa = f_reg; ol_wd = 1'b0;
        rc_we = 1'b0; rc_wa = f_reg; rc_wd = rc_rd_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                // Chain every frame in index order with a count of zero.
                nl_we = 1'b1; nl_wa = idx_reg;
                nl_wd = (idx_reg == LAST_FRAME) ? '0 : idx_reg + FRAME_BITS'(1);
                pl_we = 1'b1; pl_wa = idx_reg;
                pl_wd = (idx_reg == '0) ? LAST_FRAME : idx_reg - FRAME_BITS'(1);
                ol_we = 1'b1; ol_wa = idx_reg; ol_wd = 1'b1;
                rc_we = 1'b1; rc_wa = idx_reg; rc_wd = '0;
                idx_next = (idx_reg == LAST_FRAME) ? '0 : idx_reg + FRAME_BITS'(1);
                if (idx_reg == LAST_FRAME)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                nl_ra = frame_idx;
                pl_ra = frame_idx;
                ol_ra = frame_idx;
                rc_ra = frame_idx;
                if (start)
                begin
                    cmd_next = cmd_t'(cmd);
                    f_next   = frame_idx;
                    if (cmd_t'(cmd) == CMD_ALLOC)
                    begin
                        if (!hv_reg)
                        begin
                            done_next  = 1'b1;
                            fo_next    = '0;
                            stat_next  = STAT_EMPTY;
                            cnt_next   = '0;
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            nl_ra      = head_reg;
                            state_next = ST_ALLOC;
                        end
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_ALLOC:
            begin
                // The frame after the head is now known; fetch its entry.
                f_next     = nl_rd_reg;
                nl_ra      = nl_rd_reg;
                pl_ra      = nl_rd_reg;
                ol_ra      = nl_rd_reg;
                rc_ra      = nl_rd_reg;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                fo_next    = f_reg;
                stat_next  = STAT_OK;
                cnt_next   = rc_rd_reg;
                state_next = ST_IDLE;
                done_next  = 1'b1;
                unique case (cmd_reg)
                    CMD_ALLOC, CMD_RESERVE:
                    begin
                        if (rc_rd_reg == '1)
                        begin
                            stat_next = STAT_OVER;
                        end
                        else
                        begin
                            if (ol_rd_reg)
                            begin
                                // Unlink: join the neighbors around the frame.
                                nl_we = 1'b1; nl_wa = pl_rd_reg; nl_wd = nl_rd_reg;
                                pl_we = 1'b1; pl_wa = nl_rd_reg; pl_wd = pl_rd_reg;
                                ol_we = 1'b1; ol_wa = f_reg;     ol_wd = 1'b0;
                                if (hv_reg && head_reg == f_reg)
                                begin
                                    if (nl_rd_reg != f_reg)
                                    begin
                                        head_next = nl_rd_reg;
                                    end
                                    else
                                    begin
                                        hv_next = 1'b0;
                                    end
                                end
                            end
                            rc_we    = 1'b1;
                            rc_wd    = rc_inc;
                            cnt_next = rc_inc;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (rc_rd_reg == '0)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        else
                        begin
                            rc_we    = 1'b1;
                            rc_wd    = rc_dec;
                            cnt_next = rc_dec;
                            if (rc_dec == '0)
                            begin
                                if (!hv_reg)
                                begin
                                    // Frame becomes the sole entry.
                                    head_next = f_reg;
                                    hv_next   = 1'b1;
                                    nl_we = 1'b1; nl_wd = f_reg;
                                    pl_we = 1'b1; pl_wd = f_reg;
                                    ol_we = 1'b1; ol_wd = 1'b1;
                                end
                                else
                                begin
                                    // Link after the head: fetch head's successor.
                                    nl_ra      = head_reg;
                                    done_next  = 1'b0;
                                    state_next = ST_LINK_A;
                                end
                            end
                        end
                    end
                    CMD_PEEK:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
                empty_next = !hv_next;
            end
            ST_LINK_A:
            begin
                // nl_rd_reg holds the head's old successor.
                nl_we = 1'b1; nl_wa = f_reg;     nl_wd = nl_rd_reg;
                pl_we = 1'b1; pl_wa = nl_rd_reg; pl_wd = f_reg;
                ol_we = 1'b1; ol_wa = f_reg;     ol_wd = 1'b1;
                state_next = ST_LINK_B;
            end
            ST_LINK_B:
            begin
                nl_we = 1'b1; nl_wa = head_reg; nl_wd = f_reg;
                pl_we = 1'b1; pl_wa = f_reg;    pl_wd = head_reg;
                done_next  = 1'b1;
                empty_next = !hv_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign frame_out  = fo_reg;
    assign status     = stat_reg;
    assign ref_count  = cnt_reg;
    assign list_empty = empty_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) != ST_IDLE && $past(state_reg) != ST_INIT)
                 || $past(start))
        else $error("result word without a command");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_OVER) |-> ref_count == '1)
        else $error("overflow reported below maximum count");

    a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_UNDER) |-> ref_count == '0)
        else $error("underflow reported with nonzero count");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> list_empty == !hv_reg)
        else $error("list_empty disagrees with head valid");

    a_busy_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy) && $past(rst_n)) |-> !done || $past(state_reg) == ST_IDLE)
        else $error("busy rose inconsistently");

endmodule
`default_nettype wire
